/* src/rbp_pkg.sv */
// Shared types, constants and helpers for the range bitmap block.
`default_nettype none
package rbp_pkg;

  localparam int POS_W     = 12;
  localparam int CNT_W     = 13;
  localparam int LEN_W     = 13;
  localparam int BYTE_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int APB_AW    = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  typedef enum logic {
    REG_VECTOR_LENGTH = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             do_write;
    logic             fill;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    logic             clipped;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SWEEP
  } back_state_t;

  function automatic logic [3:0] pop8(input logic [BYTE_BITS-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* src/rbp_front.sv */
// Front end: takes input items, classifies the range and queues commands.
`default_nettype none
module rbp_front #(
  parameter int MAX_BITS = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [rbp_pkg::POS_W-1:0] in_range_start,
  input  wire logic [rbp_pkg::POS_W-1:0] in_range_end,
  input  wire logic                      in_fill_value,
  input  wire logic [((($clog2((MAX_BITS+7)/8) > 0) ? $clog2((MAX_BITS+7)/8) : 1) + 4 > 13
                     ? (($clog2((MAX_BITS+7)/8) > 0) ? $clog2((MAX_BITS+7)/8) : 1) + 4
                     : 13)-1:0]          eff_len,
  input  wire logic                      clr_busy,
  output logic                           q_valid,
  output rbp_pkg::cmd_t                  q_cmd,
  input  wire logic                      q_pop
);
  import rbp_pkg::*;

  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int AW = ($clog2(STORE_BYTES) > 0) ? $clog2(STORE_BYTES) : 1;
  localparam int LW = (AW + 4 > 13) ? AW + 4 : 13;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              cmd;
  logic              push;
  logic              nonempty;

  always_comb begin
    nonempty     = (in_range_start <= in_range_end);
    cmd.fill     = in_fill_value;
    cmd.first    = in_range_start;
    cmd.clipped  = nonempty && (LW'(in_range_end) >= eff_len);
    cmd.do_write = nonempty && (eff_len != '0) && (LW'(in_range_start) < eff_len);
    cmd.last     = cmd.clipped ? POS_W'(eff_len - LW'(1)) : in_range_end;
  end

  assign in_stall = clr_busy || (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

/* src/rbp_back.sv */
// Back end: bit store, byte sweep with read-modify-write and popcount, result register.
`default_nettype none
module rbp_back #(
  parameter int MAX_BITS = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [((($clog2((MAX_BITS+7)/8) > 0) ? $clog2((MAX_BITS+7)/8) : 1) + 4 > 13
                     ? (($clog2((MAX_BITS+7)/8) > 0) ? $clog2((MAX_BITS+7)/8) : 1) + 4
                     : 13)-1:0]          eff_len,
  output logic                           clr_busy,
  input  wire logic                      q_valid,
  input  wire rbp_pkg::cmd_t             q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [rbp_pkg::CNT_W-1:0]      out_ones_total,
  output logic [rbp_pkg::CNT_W-1:0]      out_zeros_total,
  output logic                           out_range_clipped
);
  import rbp_pkg::*;

  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int AW  = ($clog2(STORE_BYTES) > 0) ? $clog2(STORE_BYTES) : 1;
  localparam int NBW = AW + 1;
  localparam int LW  = (AW + 4 > 13) ? AW + 4 : 13;

  logic [BYTE_BITS-1:0] mem [STORE_BYTES];

  back_state_t          state_r, state_nxt;
  logic [AW-1:0]        clr_cnt_r;
  cmd_t                 cmd_r;
  logic [NBW-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                 rvalid_r;
  logic [AW-1:0]        rbyte_r;
  logic [BYTE_BITS-1:0] rdata_r;
  logic [CNT_W-1:0]     acc_r;
  logic                 out_valid_r;
  logic [CNT_W-1:0]     ones_r, zeros_r;
  logic                 clipped_r;

  logic [LW:0]          len_round;
  logic [NBW-1:0]       nbytes;
  logic                 out_free;
  logic                 last_byte;
  logic                 rd_en, we, load_out;
  logic [AW-1:0]        rd_addr, waddr;
  logic [BYTE_BITS-1:0] wdata, new_byte, keep;
  logic [CNT_W-1:0]     ones_sum, ones_val;
  logic                 clipped_val;
  logic [AW+2:0]        pos;
  logic                 in_rng;

  always_comb begin
    len_round = (LW+1)'(eff_len) + (LW+1)'(BYTE_BITS - 1);
    nbytes    = len_round[AW+3:3];
    out_free  = !out_valid_r || !out_stall;
    last_byte = rvalid_r && ({1'b0, rbyte_r} == nbytes - NBW'(1));
  end

  always_comb begin
    new_byte = rdata_r;
    keep     = '0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      pos    = {rbyte_r, 3'(BYTE_BITS - 1 - i)};
      in_rng = cmd_r.do_write && (LW'(pos) >= LW'(cmd_r.first)) &&
               (LW'(pos) <= LW'(cmd_r.last));
      if (in_rng) begin
        new_byte[i] = cmd_r.fill;
      end
      keep[i] = (LW'(pos) < eff_len);
    end
    ones_sum = acc_r + CNT_W'(pop8(new_byte & keep));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == AW'(STORE_BYTES - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid && out_free && (nbytes != '0)) state_nxt = BK_SWEEP;
      end
      BK_SWEEP: begin
        if (last_byte) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    rd_cnt_nxt  = rd_cnt_r;
    we          = 1'b0;
    waddr       = rbyte_r;
    wdata       = new_byte;
    load_out    = 1'b0;
    ones_val    = ones_sum;
    clipped_val = cmd_r.clipped;
    clr_busy    = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        clr_busy = 1'b1;
        we       = 1'b1;
        waddr    = clr_cnt_r;
        wdata    = '0;
      end
      BK_IDLE: begin
        q_pop = q_valid && out_free;
        if (q_pop) begin
          if (nbytes != '0) begin
            rd_en      = 1'b1;
            rd_cnt_nxt = NBW'(1);
          end else begin
            load_out    = 1'b1;
            ones_val    = '0;
            clipped_val = q_cmd.clipped;
          end
        end
      end
      BK_SWEEP: begin
        if (rd_cnt_r < nbytes) begin
          rd_en      = 1'b1;
          rd_addr    = rd_cnt_r[AW-1:0];
          rd_cnt_nxt = rd_cnt_r + NBW'(1);
        end
        we       = rvalid_r;
        load_out = last_byte;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rvalid_r <= rd_en;
      if (state_r == BK_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r <= rd_cnt_nxt;
    if (rd_en) rbyte_r <= rd_addr;
    if (q_pop) begin
      cmd_r <= q_cmd;
      acc_r <= '0;
    end else if ((state_r == BK_SWEEP) && rvalid_r) begin
      acc_r <= ones_sum;
    end
    if (load_out) begin
      ones_r    <= ones_val;
      zeros_r   <= CNT_W'(eff_len) - ones_val;
      clipped_r <= clipped_val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_ones_total    = ones_r;
  assign out_zeros_total   = zeros_r;
  assign out_range_clipped = clipped_r;

endmodule
`default_nettype wire

/* src/range_bitmap_with_popcount.sv */
// Range bitmap with popcount: top level, length register and APB port.
//
// Keeps a bit vector of up to MAX_BITS positions. Each input item gives an
// inclusive range (start, end) and a fill bit; positions in the range below
// the configured length are set or cleared, then one result item returns the
// set and clear counts below the length and a flag for a range that ran past it.
// Input channel in_*, result channel out_*, both valid/stall; an item moves
// at a clock edge with valid high and stall low.
// An accepted item waits in the command queue; the back end pops it, sweeps the
// ceil(len/8) bytes below len, the effective length (one read-modify-write per
// cycle on a single-port-read, single-port-write memory), then loads the result
// register behind out_valid. A new item is popped only after the sweep ends;
// with len zero no sweep runs, and items pass one a cycle while out is unstalled.
// A two-entry command queue lets items be taken while the sweep runs and while
// a finished result waits; a stalled result holds, and the sweep waits for it.
// Reset: vector_length returns to 4096, and a clearing pass zeroes the store,
// one byte a cycle over all MAX_BITS/8 bytes (512 by default), with in_stall high.
// The APB port (pready always high) writes vector_length at address 0.
`default_nettype none
module range_bitmap_with_popcount #(
  parameter int MAX_BITS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rbp_pkg::POS_W-1:0]   in_range_start,
  input  wire logic [rbp_pkg::POS_W-1:0]   in_range_end,
  input  wire logic                        in_fill_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rbp_pkg::CNT_W-1:0]        out_ones_total,
  output logic [rbp_pkg::CNT_W-1:0]        out_zeros_total,
  output logic                             out_range_clipped,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rbp_pkg::APB_AW-1:0]  paddr,
  input  wire logic [rbp_pkg::DATA_W-1:0]  pwdata,
  output logic [rbp_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import rbp_pkg::*;

  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int AW = ($clog2(STORE_BYTES) > 0) ? $clog2(STORE_BYTES) : 1;
  localparam int LW = (AW + 4 > 13) ? AW + 4 : 13;

  logic [LEN_W-1:0] vector_length_r;
  logic [LW-1:0]    eff_len;
  reg_idx_t         reg_idx;
  logic             clr_busy;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r <= LEN_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_VECTOR_LENGTH)) begin
      vector_length_r <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VECTOR_LENGTH: prdata = DATA_W'(vector_length_r);
      default:           prdata = '0;
    endcase
  end

  assign eff_len = (LW'(vector_length_r) > LW'(MAX_BITS)) ? LW'(MAX_BITS)
                                                          : LW'(vector_length_r);

  rbp_front #(.MAX_BITS(MAX_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .in_fill_value  (in_fill_value),
    .eff_len        (eff_len),
    .clr_busy       (clr_busy),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  rbp_back #(.MAX_BITS(MAX_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .eff_len           (eff_len),
    .clr_busy          (clr_busy),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ones_total    (out_ones_total),
    .out_zeros_total   (out_zeros_total),
    .out_range_clipped (out_range_clipped)
  );

endmodule
`default_nettype wire

/* src/rbp_checker.sv */
// Port-level checker for the range bitmap block, with its bind.
`default_nettype none
module rbp_checker #(
  parameter int MAX_BITS = 4096
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [rbp_pkg::CNT_W-1:0]  out_ones_total,
  input wire logic [rbp_pkg::CNT_W-1:0]  out_zeros_total,
  input wire logic                       out_range_clipped
);
  import rbp_pkg::*;

  logic [15:0] pending_r;
  logic        acc_in, acc_out;

  assign acc_in  = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 16'(acc_in) - 16'(acc_out);
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
    else $error("block not clearing after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ones_total) &&
    $stable(out_zeros_total) && $stable(out_range_clipped))
    else $error("stalled item changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result item without an input item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_ones_total) + 32'(out_zeros_total)) <= 32'(MAX_BITS))
    else $error("counts exceed vector size");

endmodule

bind range_bitmap_with_popcount rbp_checker #(.MAX_BITS(MAX_BITS)) u_rbp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_ones_total    (out_ones_total),
  .out_zeros_total   (out_zeros_total),
  .out_range_clipped (out_range_clipped)
);
`default_nettype wire

/* sim/tb_range_bitmap_with_popcount.sv */
// Testbench for range_bitmap_with_popcount: range fills and set/clear counts checked against a local bitmap.
module tb_range_bitmap_with_popcount;
  import rbp_pkg::*;

  localparam int MAX_BITS   = 4096;
  localparam int QUIET_MAX  = 8000;
  localparam int DRAIN_WAIT = 600;

  typedef struct packed {
    logic [CNT_W-1:0] ones;
    logic [CNT_W-1:0] zeros;
    logic             clipped;
  } tally_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [POS_W-1:0]    in_range_start;
  logic [POS_W-1:0]    in_range_end;
  logic                in_fill_value;
  logic                out_valid;
  logic                out_stall;
  logic [CNT_W-1:0]    out_ones_total;
  logic [CNT_W-1:0]    out_zeros_total;
  logic                out_range_clipped;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  bit                  bitmap_model [MAX_BITS];
  logic [LEN_W-1:0]    length_reg = LEN_RESET;
  tally_t              pending_tallies [$];
  int                  mismatches;
  int                  quiet_cycles;
  int                  send_idle_pct;
  int                  recv_idle_pct;

  range_bitmap_with_popcount #(.MAX_BITS(MAX_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .in_fill_value     (in_fill_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ones_total    (out_ones_total),
    .out_zeros_total   (out_zeros_total),
    .out_range_clipped (out_range_clipped),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one range fill to the local bitmap and returns the counts it should report.
  function automatic tally_t apply_range(input logic [POS_W-1:0] first_pos,
                                         input logic [POS_W-1:0] last_pos,
                                         input logic fill);
    tally_t t;
    int     eff_len;
    int     stop;
    int     ones;
    eff_len   = (length_reg > MAX_BITS) ? MAX_BITS : int'(length_reg);
    t.clipped = 1'b0;
    if (first_pos <= last_pos) begin
      stop = int'(last_pos);
      if (int'(last_pos) >= eff_len) begin
        t.clipped = 1'b1;
        stop      = (eff_len == 0) ? 0 : eff_len - 1;
      end
      if (eff_len != 0 && int'(first_pos) < eff_len) begin
        for (int p = int'(first_pos); p <= stop; p++) bitmap_model[p] = fill;
      end
    end
    ones = 0;
    for (int p = 0; p < eff_len; p++) ones += int'(bitmap_model[p]);
    t.ones  = CNT_W'(ones);
    t.zeros = CNT_W'(eff_len - ones);
    return t;
  endfunction

  task automatic send_item(input int first_pos, input int last_pos, input bit fill);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_range_start <= POS_W'(first_pos);
    in_range_end   <= POS_W'(last_pos);
    in_fill_value  <= fill;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_tallies.push_back(apply_range(POS_W'(first_pos), POS_W'(last_pos), fill));
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_VECTOR_LENGTH) length_reg = data[LEN_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_check(input reg_idx_t idx, input logic [DATA_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $display("%0t: register read expected %0d, got %0d", $time, want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_value();
    cfg_check(REG_VECTOR_LENGTH, DATA_W'(LEN_RESET));
  endtask

  task automatic test_full_length_fills();
    send_item(0, 4095, 1'b1);
    send_item(0, 4095, 1'b0);
    send_item(0, 0, 1'b1);
    send_item(4095, 4095, 1'b1);
    send_item(5, 3, 1'b1);
    send_item(100, 200, 1'b1);
    send_item(150, 150, 1'b0);
    drain_results();
  endtask

  task automatic test_length_edges();
    cfg_write(REG_VECTOR_LENGTH, 32'd1);
    send_item(0, 0, 1'b1);
    send_item(0, 4095, 1'b0);
    send_item(1, 4095, 1'b1);
    send_item(4095, 0, 1'b1);
    drain_results();
    cfg_write(REG_VECTOR_LENGTH, 32'd0);
    send_item(0, 0, 1'b1);
    send_item(5, 4, 1'b1);
    drain_results();
    cfg_write(REG_UNUSED, 32'h0000_0123);
    cfg_check(REG_VECTOR_LENGTH, 32'd0);
    // upper bits dropped, 8191 saturates to full length
    cfg_write(REG_VECTOR_LENGTH, 32'hFFFF_FFFF);
    send_item(4000, 4095, 1'b1);
    drain_results();
    cfg_write(REG_VECTOR_LENGTH, 32'd12);
    send_item(3, 20, 1'b1);
    send_item(11, 11, 1'b0);
    drain_results();
    cfg_write(REG_VECTOR_LENGTH, 32'd4096);
    send_item(2000, 1999, 1'b0);
    send_item(4001, 4001, 1'b0);
    drain_results();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
    int done;
    int seg;
    int eff_len;
    int pick;
    int first_pos;
    int last_pos;
    logic [DATA_W-1:0] len_word;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < n_items) begin
      drain_results();
      pick = $urandom_range(99);
      len_word = $urandom;
      if (pick < 6)       len_word[LEN_W-1:0] = LEN_W'(4096 + $urandom_range(0, 4095));
      else if (pick < 9)  len_word[LEN_W-1:0] = '0;
      else                len_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 256));
      cfg_write(REG_VECTOR_LENGTH, len_word);
      eff_len = (length_reg > MAX_BITS) ? MAX_BITS : int'(length_reg);
      seg = (eff_len == MAX_BITS) ? 5 : (eff_len == 0) ? 10 : 30;
      for (int i = 0; i < seg && done < n_items; i++) begin
        pick = $urandom_range(99);
        if (pick < 70 && eff_len > 0) begin
          first_pos = $urandom_range(0, eff_len - 1);
          if ($urandom_range(1)) last_pos = $urandom_range(first_pos, eff_len - 1);
          else last_pos = first_pos + $urandom_range(0, 7);
          if (last_pos > eff_len - 1) last_pos = eff_len - 1;
        end else if (pick < 85) begin
          first_pos = $urandom_range(0, 4095);
          last_pos  = $urandom_range(first_pos, 4095);
        end else if (pick < 95) begin
          first_pos = $urandom_range(1, 4095);
          last_pos  = $urandom_range(0, first_pos - 1);
        end else begin
          first_pos = $urandom_range(0, 4095);
          last_pos  = $urandom_range(0, 4095);
        end
        send_item(first_pos, last_pos, 1'($urandom_range(1)));
        done++;
      end
    end
    drain_results();
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    tally_t exp_t;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected result, ones %0d zeros %0d clipped %0d", $time,
                 out_ones_total, out_zeros_total, out_range_clipped);
        mismatches++;
      end else begin
        exp_t = pending_tallies.pop_front();
        if (out_ones_total !== exp_t.ones) begin
          $display("%0t: ones_total expected %0d, got %0d", $time, exp_t.ones,
                   out_ones_total);
          mismatches++;
        end
        if (out_zeros_total !== exp_t.zeros) begin
          $display("%0t: zeros_total expected %0d, got %0d", $time, exp_t.zeros,
                   out_zeros_total);
          mismatches++;
        end
        if (out_range_clipped !== exp_t.clipped) begin
          $display("%0t: range_clipped expected %0d, got %0d", $time, exp_t.clipped,
                   out_range_clipped);
          mismatches++;
        end
      end
    end
  end

  // Covers the clearing pass after reset and the longest sweep plus stalls.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_MAX) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("tb_range_bitmap_with_popcount: errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_range_start = '0;
    in_range_end   = '0;
    in_fill_value  = 1'b0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 34;
    recv_idle_pct  = 76;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_value();
    test_full_length_fills();
    test_length_edges();
    test_random(34, 76, 350);
    test_random(76, 34, 350);
    test_random(0, 0, 350);

    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_range_bitmap_with_popcount: clean");
    end else begin
      $display("tb_range_bitmap_with_popcount: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rbp_pkg.sv
src/rbp_front.sv
src/rbp_back.sv
src/range_bitmap_with_popcount.sv
src/rbp_checker.sv
sim/tb_range_bitmap_with_popcount.sv
